>>> src/keyframe_vector_lerp_defines.svh
// Assertion macros shared by the keyframe_vector_lerp checker.
// No dependencies; included by the checker file.
`ifndef KEYFRAME_VECTOR_LERP_DEFINES_SVH
`define KEYFRAME_VECTOR_LERP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define KVL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define KVL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/kvl_pkg.sv
// Shared types and constants for the keyframe vector interpolator.
// No dependencies; used by every module of the block.
`default_nettype none

package kvl_pkg;

   localparam int VAL_W    = 32;
   localparam int TIME_W   = 32;
   localparam int KC_W     = 7;
   localparam int KIDX_W   = 6;
   localparam int FRAC_W   = 16;
   localparam int DIFF_W   = VAL_W + 1;
   localparam int PROD_W   = FRAC_W + 1 + DIFF_W;
   localparam int NUM_COMP = 3;
   localparam int COMP_W   = 2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]       key_time;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] z;
   } key_word_type;

   typedef struct packed {
      logic              key_wr;
      logic              time_load;
      logic              rd_en;
      logic              prev_load;
      logic              cap_key;
      logic              cap_oor;
      logic              seg_load;
      logic              mul;
      logic              acc;
      logic [COMP_W-1:0] comp;
      logic              out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic t_lt_key;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/kvl_div.sv
// Restoring divider giving the Q0.16 interpolation factor, one bit a cycle.
// Depends on kvl_pkg.
`default_nettype none

module kvl_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [kvl_pkg::TIME_W-1:0]   num,
   input  logic [kvl_pkg::TIME_W-1:0]   den,
   output logic [kvl_pkg::FRAC_W-1:0]   quot,
   output logic                         done
);
   import kvl_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W);

   logic [TIME_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [FRAC_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [TIME_W:0]   rem2, rem_sub;
   logic              fits;

   // The numerator is below the denominator, so sixteen steps give the quotient.
   always_comb begin
      rem2    = {rem_ff, 1'b0};
      rem_sub = rem2 - {1'b0, den_ff};
      fits    = rem2 >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[TIME_W-1:0] : rem2[TIME_W-1:0];
         quot_in = {quot_ff[FRAC_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> src/kvl_dp.sv
// Datapath: key store, segment registers, divider, shared multiplier and
// the output register. Depends on kvl_pkg and kvl_div.
`default_nettype none

module kvl_dp #(
   parameter int MAX_KEYS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [kvl_pkg::KIDX_W-1:0]         req_key_index,
   input  logic [kvl_pkg::TIME_W-1:0]         req_key_time,
   input  logic signed [kvl_pkg::VAL_W-1:0]   req_value_x,
   input  logic signed [kvl_pkg::VAL_W-1:0]   req_value_y,
   input  logic signed [kvl_pkg::VAL_W-1:0]   req_value_z,
   input  logic [kvl_pkg::TIME_W-1:0]         req_sample_time,
   input  kvl_pkg::dp_cmd_type                cmd,
   input  logic [$clog2(MAX_KEYS)-1:0]        rd_addr,
   output kvl_pkg::dp_status_type             status,
   output logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_x,
   output logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_y,
   output logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_z,
   output logic                               rsp_out_of_range
);
   import kvl_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEYS);

   key_word_type key_mem [MAX_KEYS];
   key_word_type rd_ff, prev_ff;
   logic [TIME_W-1:0]       time_ff;
   logic signed [DIFF_W-1:0] diff_ff [NUM_COMP];
   logic signed [VAL_W-1:0]  res_ff  [NUM_COMP];
   logic signed [PROD_W-1:0] prod_ff;
   logic                     oor_ff;
   logic signed [VAL_W-1:0]  out_x_ff, out_y_ff, out_z_ff;
   logic                     out_oor_ff;

   logic signed [VAL_W-1:0] start_v [NUM_COMP];
   logic signed [VAL_W-1:0] rd_v    [NUM_COMP];
   logic                    wr_ok;
   logic [IDX_W-1:0]        wr_addr;
   logic [TIME_W-1:0]       div_num, div_den;
   logic [FRAC_W-1:0]       factor;
   logic                    div_done;

   assign wr_ok   = 32'(req_key_index) < MAX_KEYS;
   assign wr_addr = IDX_W'(req_key_index);

   always_ff @(posedge clock) begin
      if (cmd.key_wr && wr_ok) begin
         key_mem[wr_addr] <= '{key_time: req_key_time, x: req_value_x,
                               y: req_value_y, z: req_value_z};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= key_mem[rd_addr];
      end
   end

   always_comb begin
      start_v[0] = prev_ff.x;
      start_v[1] = prev_ff.y;
      start_v[2] = prev_ff.z;
      rd_v[0]    = rd_ff.x;
      rd_v[1]    = rd_ff.y;
      rd_v[2]    = rd_ff.z;
   end

   assign div_num = time_ff - prev_ff.key_time;
   assign div_den = rd_ff.key_time - prev_ff.key_time;

   kvl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.seg_load),
      .num   (div_num),
      .den   (div_den),
      .quot  (factor),
      .done  (div_done)
   );

   assign status.t_lt_key = time_ff < rd_ff.key_time;
   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.time_load) begin
         time_ff <= req_sample_time;
      end
      if (cmd.prev_load) begin
         prev_ff <= rd_ff;
      end
      if (cmd.cap_key) begin
         for (int c = 0; c < NUM_COMP; c++) begin
            res_ff[c] <= rd_v[c];
         end
         oor_ff <= cmd.cap_oor;
      end
      if (cmd.seg_load) begin
         for (int c = 0; c < NUM_COMP; c++) begin
            diff_ff[c] <= {rd_v[c][VAL_W-1], rd_v[c]} - {start_v[c][VAL_W-1], start_v[c]};
         end
         oor_ff <= 1'b0;
      end
      // The factor is non-negative, so a zero top bit makes it a signed operand.
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, factor}) * diff_ff[cmd.comp];
      end
      // Arithmetic shift by 16 floors, and only the low 32 bits survive.
      if (cmd.acc) begin
         res_ff[cmd.comp] <= start_v[cmd.comp] + prod_ff[FRAC_W+VAL_W-1:FRAC_W];
      end
      if (cmd.out_load) begin
         out_x_ff   <= res_ff[0];
         out_y_ff   <= res_ff[1];
         out_z_ff   <= res_ff[2];
         out_oor_ff <= oor_ff;
      end
   end

   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_z        = out_z_ff;
   assign rsp_out_of_range = out_oor_ff;

endmodule

`default_nettype wire

>>> src/kvl_ctrl.sv
// Controller: handshakes, key count register, search sequencer and the
// interpolation schedule. Depends on kvl_pkg.
`default_nettype none

module kvl_ctrl #(
   parameter int MAX_KEYS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kvl_pkg::KC_W-1:0]       csr_key_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output kvl_pkg::dp_cmd_type            cmd,
   output logic [$clog2(MAX_KEYS)-1:0]    rd_addr,
   input  kvl_pkg::dp_status_type         status
);
   import kvl_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, idx_nxt, n_eff;
   logic [COMP_W-1:0] comp_ff, comp_in;
   logic [KC_W-1:0]   key_count_ff, key_count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Key count saturated into one up to the store depth.
   always_comb begin
      if (key_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(key_count_ff) > MAX_KEYS) begin
         n_eff = CNT_W'(MAX_KEYS);
      end else begin
         n_eff = CNT_W'(key_count_ff);
      end
   end

   assign idx_nxt      = idx_ff + 1'b1;
   assign key_count_in = csr_valid ? csr_key_count : key_count_ff;

   // idx_ff is the index of the key that the read register holds.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      comp_in      = comp_ff;
      cmd          = '0;
      rd_addr      = idx_nxt[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.key_wr = 1'b1;
               end else begin
                  cmd.time_load = 1'b1;
                  cmd.rd_en     = 1'b1;
                  rd_addr       = '0;
                  idx_in        = '0;
                  state_in      = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            cmd.prev_load = 1'b1;
            if (n_eff == CNT_W'(1)) begin
               cmd.cap_key = 1'b1;
               state_in    = S_OUT;
            end else if (status.t_lt_key) begin
               cmd.cap_key = 1'b1;
               cmd.cap_oor = 1'b1;
               state_in    = S_OUT;
            end else begin
               cmd.rd_en = 1'b1;
               idx_in    = idx_nxt;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.t_lt_key) begin
               cmd.seg_load = 1'b1;
               comp_in      = '0;
               state_in     = S_DIV;
            end else begin
               cmd.prev_load = 1'b1;
               if (idx_nxt == n_eff) begin
                  cmd.cap_key = 1'b1;
                  cmd.cap_oor = 1'b1;
                  state_in    = S_OUT;
               end else begin
                  cmd.rd_en = 1'b1;
                  idx_in    = idx_nxt;
               end
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            cmd.comp = comp_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            cmd.comp = comp_ff;
            if (comp_ff == COMP_W'(NUM_COMP - 1)) begin
               state_in = S_OUT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         comp_ff      <= '0;
         key_count_ff <= KC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         comp_ff      <= comp_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> src/keyframe_vector_lerp.sv
// Top level of the keyframe vector interpolator: controller plus datapath.
// Depends on kvl_pkg, kvl_ctrl and kvl_dp.
//
// Usage. Items arrive on the req_ channel (valid/ready). A load item
// (req_kind low) writes time and x, y, z of one key at req_key_index into
// the key store and gives no result. A query item (req_kind high) samples
// the track at req_sample_time and gives one item on the rsp_ channel: the
// interpolated vector, or the first or last key with rsp_out_of_range set
// when the time lies outside the keys; with one key in use, key 0 unflagged.
// The csr_ channel writes the key count; it is always ready and is to be
// written only while the block is idle.
// A query runs a search that reads one key per cycle from the single-port
// key store, then the one-bit-a-step divider and the shared multiplier;
// a clamped answer skips the divider and the multiplier.
// One item is worked on at a time; req_ready is high while idle.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls; a second query waits for that register to empty.
// Reset clears the controller and sets the key count to one; the key
// store is not cleared and every key must be loaded before it is used.
`default_nettype none

module keyframe_vector_lerp #(
   parameter int MAX_KEYS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [kvl_pkg::KIDX_W-1:0]         req_key_index,
   input  logic [kvl_pkg::TIME_W-1:0]         req_key_time,
   input  logic signed [kvl_pkg::VAL_W-1:0]   req_value_x,
   input  logic signed [kvl_pkg::VAL_W-1:0]   req_value_y,
   input  logic signed [kvl_pkg::VAL_W-1:0]   req_value_z,
   input  logic [kvl_pkg::TIME_W-1:0]         req_sample_time,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_x,
   output logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_y,
   output logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_z,
   output logic                               rsp_out_of_range,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kvl_pkg::KC_W-1:0]           csr_key_count
);
   import kvl_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEYS);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [IDX_W-1:0]  rd_addr;

   // The controller sequences the search and arithmetic; it sees req_kind and the key count but no key or sample data.
   kvl_ctrl #(
      .MAX_KEYS (MAX_KEYS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_key_count (csr_key_count),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .status        (status)
   );

   // The datapath holds the key store and the output register.
   kvl_dp #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_key_index    (req_key_index),
      .req_key_time     (req_key_time),
      .req_value_x      (req_value_x),
      .req_value_y      (req_value_y),
      .req_value_z      (req_value_z),
      .req_sample_time  (req_sample_time),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .status           (status),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

`default_nettype wire

>>> src/kvl_checker.sv
// Port-level checks for keyframe_vector_lerp, attached by a bind.
// Depends on kvl_pkg and keyframe_vector_lerp_defines.svh.
`default_nettype none
`include "keyframe_vector_lerp_defines.svh"

module kvl_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_kind,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_x,
   input  logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_y,
   input  logic signed [kvl_pkg::VAL_W-1:0]   rsp_out_z,
   input  logic                               rsp_out_of_range
);
   import kvl_pkg::*;

   // A stalled result keeps its valid and its payload.
   `KVL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_out_of_range), "result changed while stalled")

   // No result is offered in the cycle after reset.
   `KVL_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

   // A load item never raises a result.
   `KVL_ASSERT(a_load_silent, clock, reset, req_valid && req_ready && req_kind == KIND_LOAD && !rsp_valid |=> !rsp_valid, "load item produced a result")

   // A query keeps the block busy for at least the next cycle.
   `KVL_ASSERT(a_query_busy, clock, reset, req_valid && req_ready && req_kind == KIND_QUERY |=> !req_ready, "new item accepted during a query")

endmodule

bind keyframe_vector_lerp kvl_checker u_kvl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_x        (rsp_out_x),
   .rsp_out_y        (rsp_out_y),
   .rsp_out_z        (rsp_out_z),
   .rsp_out_of_range (rsp_out_of_range)
);

`default_nettype wire

>>> tb/kvl_track_checker.sv
// Scoreboard for keyframe_vector_lerp: watches the req_, rsp_ and csr_ channels,
// predicts every query result from its own copy of the key store and key count,
// and compares. Depends on kvl_pkg.
module kvl_track_checker #(
   parameter int MAX_KEYS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_kind,
   input  logic [kvl_pkg::KIDX_W-1:0]       req_key_index,
   input  logic [kvl_pkg::TIME_W-1:0]       req_key_time,
   input  logic signed [kvl_pkg::VAL_W-1:0] req_value_x,
   input  logic signed [kvl_pkg::VAL_W-1:0] req_value_y,
   input  logic signed [kvl_pkg::VAL_W-1:0] req_value_z,
   input  logic [kvl_pkg::TIME_W-1:0]       req_sample_time,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [kvl_pkg::VAL_W-1:0] rsp_out_x,
   input  logic signed [kvl_pkg::VAL_W-1:0] rsp_out_y,
   input  logic signed [kvl_pkg::VAL_W-1:0] rsp_out_z,
   input  logic                             rsp_out_of_range,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [kvl_pkg::KC_W-1:0]         csr_key_count,
   output int unsigned                      mismatch_count,
   output int unsigned                      samples_outstanding
);
   import kvl_pkg::*;

   typedef struct packed {
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
      logic [VAL_W-1:0] z;
      logic             oor;
   } sample_type;

   logic [TIME_W-1:0] key_time_store [MAX_KEYS];
   logic [VAL_W-1:0]  key_x_store    [MAX_KEYS];
   logic [VAL_W-1:0]  key_y_store    [MAX_KEYS];
   logic [VAL_W-1:0]  key_z_store    [MAX_KEYS];
   logic [KC_W-1:0]   key_count_q;
   sample_type        pending_samples [$];
   int unsigned       mismatches;

   initial begin
      mismatch_count      = 0;
      samples_outstanding = 0;
      mismatches          = 0;
      key_count_q         = KC_W'(1);
   end

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] sample mismatch on %s: got %h, want %h", $time, field, got, want);
      mismatches++;
   endtask

   function automatic sample_type stored_key(int unsigned k, logic oor);
      sample_type r;
      r.x   = key_x_store[k];
      r.y   = key_y_store[k];
      r.z   = key_z_store[k];
      r.oor = oor;
      return r;
   endfunction

   // start + floor(factor * (end - start) / 2^16), all in signed 64-bit.
   function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                  logic [15:0] factor);
      longint start, delta, prod;
      start = longint'($signed(a));
      delta = longint'($signed(b)) - start;
      prod  = longint'({48'd0, factor}) * delta;
      start = start + (prod >>> 16);
      return start[31:0];
   endfunction

   function automatic sample_type sample_track(logic [TIME_W-1:0] t);
      int unsigned       n, seg;
      logic [TIME_W-1:0] lead32, span32;
      logic [63:0]       ratio;
      logic [15:0]       factor;
      sample_type        r;
      n = key_count_q;
      if (n < 1) n = 1;
      if (n > MAX_KEYS) n = MAX_KEYS;
      if (n == 1) return stored_key(0, 1'b0);
      if (t < key_time_store[0]) return stored_key(0, 1'b1);
      for (seg = 0; seg + 1 < n; seg++) begin
         if (t < key_time_store[seg + 1]) break;
      end
      if (seg + 1 >= n) return stored_key(n - 1, 1'b1);
      // Here the segment start is at or below t and its end above it.
      lead32 = t - key_time_store[seg];
      span32 = key_time_store[seg + 1] - key_time_store[seg];
      ratio  = ({32'd0, lead32} << 16) / {32'd0, span32};
      if (ratio > 64'd65535) ratio = 64'd65535;
      factor = ratio[15:0];
      r.x   = lerp_component(key_x_store[seg], key_x_store[seg + 1], factor);
      r.y   = lerp_component(key_y_store[seg], key_y_store[seg + 1], factor);
      r.z   = lerp_component(key_z_store[seg], key_z_store[seg + 1], factor);
      r.oor = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         pending_samples.delete();
         key_count_q = KC_W'(1);
      end else begin
         if (csr_valid && csr_ready) key_count_q = csr_key_count;
         // The result is checked before a query accepted at the same edge is queued.
         if (rsp_valid && rsp_ready) begin
            if (pending_samples.size() == 0) begin
               report_mismatch("unexpected result, out_x", rsp_out_x, 32'h0);
            end else begin
               want = pending_samples.pop_front();
               if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
               if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
               if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
               if (rsp_out_of_range !== want.oor) begin
                  report_mismatch("out_of_range", {31'd0, rsp_out_of_range}, {31'd0, want.oor});
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               key_time_store[req_key_index] = req_key_time;
               key_x_store[req_key_index]    = req_value_x;
               key_y_store[req_key_index]    = req_value_y;
               key_z_store[req_key_index]    = req_value_z;
            end else begin
               pending_samples = {pending_samples, sample_track(req_sample_time)};
            end
         end
      end
      mismatch_count      <= mismatches;
      samples_outstanding <= pending_samples.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the keyframe_vector_lerp testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on kvl_pkg, keyframe_vector_lerp and
// kvl_track_checker.
module tb_top;
   import kvl_pkg::*;

   localparam int TRACK_DEPTH   = 64;
   // Settling pause; it covers the longest query with margin.
   localparam int SETTLE_CYCLES = 120;
   // Long receiver hold-off that forces the block to back up its input.
   localparam int HOLD_CYCLES   = 400;
   // Cycles without any accepted item before the run is declared hung.
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 94;
   localparam int PHASE_COUNT   = 11;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } stall_mode_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_kind;
   logic [KIDX_W-1:0]        req_key_index;
   logic [TIME_W-1:0]        req_key_time;
   logic signed [VAL_W-1:0]  req_value_x;
   logic signed [VAL_W-1:0]  req_value_y;
   logic signed [VAL_W-1:0]  req_value_z;
   logic [TIME_W-1:0]        req_sample_time;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [VAL_W-1:0]  rsp_out_x;
   logic signed [VAL_W-1:0]  rsp_out_y;
   logic signed [VAL_W-1:0]  rsp_out_z;
   logic                     rsp_out_of_range;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [KC_W-1:0]          csr_key_count;

   int unsigned mismatch_count;
   int unsigned samples_outstanding;

   // Stimulus-side view of the track: the key times that were loaded and the
   // number of keys in use. It only steers the choice of sample times.
   logic [TIME_W-1:0] track_time [TRACK_DEPTH];
   int unsigned       track_count;
   int unsigned       items_sent;
   int unsigned       burst_left;
   int unsigned       idle_cycles;
   bit                hold_wanted;
   bit                hold_done;

   keyframe_vector_lerp #(.MAX_KEYS(TRACK_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_key_index    (req_key_index),
      .req_key_time     (req_key_time),
      .req_value_x      (req_value_x),
      .req_value_y      (req_value_y),
      .req_value_z      (req_value_z),
      .req_sample_time  (req_sample_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_key_count    (csr_key_count)
   );

   kvl_track_checker #(.MAX_KEYS(TRACK_DEPTH)) u_track_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_key_index       (req_key_index),
      .req_key_time        (req_key_time),
      .req_value_x         (req_value_x),
      .req_value_y         (req_value_y),
      .req_value_z         (req_value_z),
      .req_sample_time     (req_sample_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_z           (rsp_out_z),
      .rsp_out_of_range    (rsp_out_of_range),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_key_count       (csr_key_count),
      .mismatch_count      (mismatch_count),
      .samples_outstanding (samples_outstanding)
   );

   // Clock with a period of 12 time units.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: any accepted item on any channel restarts the count. A run that
   // stalls this long has hung, and an expectation that never gets its result
   // ends up here too.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver. It switches among several ready patterns so that stalls land
   // on every phase of the block's work, including stretches with no stall.
   // Once, on request from the stimulus, it holds ready low for a long time
   // so that the output register fills and the block stops taking queries.
   initial begin
      stall_mode_type stall_mode;
      int unsigned    mode_left;
      rsp_ready  = 1'b0;
      stall_mode = READY_ALWAYS;
      mode_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
         end
         mode_left--;
         case (stall_mode)
            READY_ALWAYS: begin
               rsp_ready = 1'b1;
            end
            READY_COIN: begin
               rsp_ready = 1'($urandom_range(0, 1));
            end
            READY_SPARSE: begin
               rsp_ready = ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready = ((mode_left % 8) < 3);
            end
         endcase
      end
   end

   // Offers one item at the next falling edge and returns right after the
   // rising edge that accepts it. Inside a burst valid stays high and the next
   // call swaps the payload at the following falling edge; at the end of a
   // burst valid drops for a random gap. A caller that stops sending must
   // lower valid at the next falling edge itself.
   task automatic offer_item(logic kind, logic [KIDX_W-1:0] idx, logic [TIME_W-1:0] kt,
                             logic [VAL_W-1:0] vx, logic [VAL_W-1:0] vy,
                             logic [VAL_W-1:0] vz, logic [TIME_W-1:0] st);
      int unsigned gap;
      @(negedge clock);
      req_valid       = 1'b1;
      req_kind        = kind;
      req_key_index   = idx;
      req_key_time    = kt;
      req_value_x     = vx;
      req_value_y     = vy;
      req_value_z     = vz;
      req_sample_time = st;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 60);
         else burst_left = $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // A load also carries a random sample time, which the block ignores.
   task automatic load_key(logic [KIDX_W-1:0] idx, logic [TIME_W-1:0] t,
                           logic [VAL_W-1:0] vx, logic [VAL_W-1:0] vy,
                           logic [VAL_W-1:0] vz);
      track_time[idx] = t;
      offer_item(KIND_LOAD, idx, t, vx, vy, vz, $urandom);
   endtask

   // A query carries random key fields, which the block ignores.
   task automatic query_at(logic [TIME_W-1:0] t);
      offer_item(KIND_QUERY, KIDX_W'($urandom), $urandom, $urandom, $urandom, $urandom, t);
   endtask

   // Writes the key count once the block is idle: valid goes low, every
   // expected result has to arrive, and then a pause covers a load that
   // may still be in flight without a result.
   task automatic write_key_count(logic [KC_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      @(posedge clock);
      while (samples_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid     = 1'b1;
      csr_key_count = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid     = 1'b0;
      csr_key_count = KC_W'($urandom);
      // A count of zero acts as one key, anything above the store as a full store.
      if (value == 0) track_count = 1;
      else if (value > TRACK_DEPTH) track_count = TRACK_DEPTH;
      else track_count = value;
   endtask

   // Component values: mostly random, with the two extremes often enough that
   // the widest differences between neighboring keys show up.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Sample times: mostly inside a segment of the loaded track, the rest on
   // key times exactly, just before the first key, past the last key, at the
   // ends of the time range, or anywhere.
   function automatic logic [TIME_W-1:0] pick_sample();
      int unsigned       k;
      logic [TIME_W-1:0] lo, hi;
      if (track_count < 2) return $urandom;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return track_time[0] - 32'd1;
         2: return track_time[$urandom_range(0, track_count - 1)];
         3: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         4: return track_time[track_count - 1] + $urandom_range(0, 3);
         default: begin
            k  = $urandom_range(0, track_count - 2);
            lo = track_time[k];
            hi = track_time[k + 1];
            if (hi > lo) return lo + $urandom_range(0, hi - lo - 1);
            return lo;
         end
      endcase
   endfunction

   // Loads keys 0 to n-1 as one track. Most tracks are sorted in time with
   // wide, tight or coarse steps; coarse steps may repeat a time and so give
   // zero-length segments. One shape in ten has random, unsorted times.
   task automatic load_track(int unsigned n);
      int unsigned     shape, k;
      longint unsigned step_max, stamp, step;
      shape = $urandom_range(0, 9);
      if (n < 2) step_max = 1;
      else if (shape < 5) step_max = 64'hFFFF_FFFF / (n - 1);
      else if (shape < 7) step_max = $urandom_range(1, 16);
      else step_max = 64'h4_0000;
      stamp = $urandom_range(0, 32'hFFFF_FFFF - 32'(step_max * (n - 1)));
      for (k = 0; k < n; k++) begin
         if (shape == 9) stamp = $urandom;
         load_key(k[KIDX_W-1:0], stamp[TIME_W-1:0], pick_value(), pick_value(),
                  pick_value());
         if (shape < 7) step = $urandom_range(1, 32'(step_max));
         else step = $urandom_range(0, 32'(step_max));
         stamp = stamp + step;
      end
   endtask

   initial begin
      logic [KC_W-1:0] phase_counts [PHASE_COUNT];
      logic [KC_W-1:0] setting;
      int unsigned     ph, phase_end, k;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_LOAD;
      req_key_index   = '0;
      req_key_time    = '0;
      req_value_x     = '0;
      req_value_y     = '0;
      req_value_z     = '0;
      req_sample_time = '0;
      csr_valid       = 1'b0;
      csr_key_count   = '0;
      hold_wanted     = 1'b0;
      hold_done       = 1'b0;
      items_sent      = 0;
      burst_left      = 0;
      idle_cycles     = 0;
      track_count     = 1;
      // Key counts per random phase, the extremes and the values outside the
      // legal range among them; slot 8 is drawn at random.
      phase_counts = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd3, 7'd65, 7'd1, 7'd8, 7'd0,
                       7'd64, 7'd16};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. After reset the track has one key, so every query
      // returns key 0 in range, whatever the sample time.
      load_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      query_at(32'h0000_0000);
      query_at(32'hFFFF_FFFF);
      // A count of zero behaves as a single key.
      write_key_count(7'd0);
      query_at(32'h0001_0000);
      // Four keys with extreme values; keys 1 and 2 share a time, so the
      // segment between them can never be chosen.
      load_key(6'd1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      load_key(6'd2, 32'h0002_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_0000);
      load_key(6'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
      write_key_count(7'd4);
      query_at(32'h0000_0000);   // before the first key: clamped to key 0
      query_at(32'h0001_0000);   // exactly on key 0: factor zero
      query_at(32'h0001_8000);   // halfway along the first segment
      query_at(32'h0001_FFFF);   // largest factor on a short segment
      query_at(32'h0002_0000);   // skips the zero-length segment
      query_at(32'hFFFF_FFFE);   // just short of the last key over a huge span
      query_at(32'hFFFF_FFFF);   // on the last key: past the last segment
      load_key(6'd63, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);

      // Random phases. Each writes a key count, loads a complete track for
      // it so that no query can touch a key that was never loaded, then mixes
      // queries with loads. Some loads give a key new values at its time;
      // the rest write any index with any time and may unsort the track.
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         setting = (ph == 8) ? 7'($urandom_range(1, TRACK_DEPTH)) : phase_counts[ph];
         write_key_count(setting);
         phase_end = items_sent + PHASE_ITEMS;
         load_track(track_count);
         // On the three-key phase the receiver holds off for a long stretch.
         if (ph == 4) hold_wanted = 1'b1;
         while (items_sent < phase_end) begin
            case ($urandom_range(0, 9))
               7: begin
                  k = $urandom_range(0, track_count - 1);
                  load_key(k[KIDX_W-1:0], track_time[k], pick_value(), pick_value(),
                           pick_value());
               end
               8, 9: begin
                  load_key(KIDX_W'($urandom), $urandom, pick_value(), pick_value(),
                           pick_value());
               end
               default: begin
                  query_at(pick_sample());
               end
            endcase
         end
      end

      // Drain: stop sending, wait for every expected result, then give the
      // block time to show any result that was not asked for.
      @(negedge clock);
      req_valid = 1'b0;
      @(posedge clock);
      while (samples_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
